// File: src/mqmm_pkg.sv
package mqmm_pkg;

	localparam int IDX_W = 10;
	localparam int TBL_DEPTH = 1 << IDX_W;
	localparam int unsigned MQMM_NUM_ITEMS = 1023;

	typedef enum logic [1:0] {
		OP_MOVE  = 2'd0,
		OP_MERGE = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef struct packed {
		op_t              operation;
		logic [IDX_W-1:0] first_operand;
		logic [IDX_W-1:0] second_operand;
	} in_t;

	typedef struct packed {
		logic [IDX_W-1:0] queue_head;
		logic [IDX_W-1:0] item_successor;
	} out_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_MV_LD,
		ST_FIND_A,
		ST_FIND_B,
		ST_MV_A,
		ST_MV_B,
		ST_MV_C,
		ST_MV_D,
		ST_MG_A,
		ST_MG_B,
		ST_MG_C,
		ST_MG_D,
		ST_RD
	} state_t;

endpackage

// File: src/mqmm_ram.sv
module mqmm_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/multi_queue_move_merge_unit.sv
// Queue move/merge engine over six 1024-entry tables held in single-port-write RAMs.
// After reset the block runs a clearing pass over every entry, one entry of every table
// per cycle, with in_ready low. Commands are then taken one at a time. A move loads the
// item's links and home, runs two root searches and relinks in ST_MV_A to ST_MV_D; a
// merge runs the same searches and joins the queues in ST_MG_A to ST_MG_D, or ends after
// the searches when both labels share a root. The root searches walk the parent table
// one link per cycle through its read port; the first node of each search is then
// pointed straight at its root. The read result sits in an output register, so the
// next command is taken while it waits.
module multi_queue_move_merge_unit
	import mqmm_pkg::*;
#(
	parameter int unsigned NUM_ITEMS = MQMM_NUM_ITEMS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	typedef logic [IDX_W-1:0] idx_t;

	function automatic logic in_range(idx_t v);
		return (v != '0) && (32'(v) <= NUM_ITEMS);
	endfunction

	state_t state_q, state_d;

	idx_t clr_q, cur_q, start_q, a_q, b_q, nx_q, pv_q, ra_q, rb_q, qfa_q, qla_q;
	op_t  op_q;
	logic out_valid_q;
	out_t out_q;

	logic nl_we, pl_we, hq_we, pa_we, qf_we, ql_we;
	logic nl_re, pl_re, hq_re, pa_re, qf_re, ql_re;
	idx_t nl_wa, pl_wa, hq_wa, pa_wa, qf_wa, ql_wa;
	idx_t nl_wd, pl_wd, hq_wd, pa_wd, qf_wd, ql_wd;
	idx_t nl_ra, pl_ra, hq_ra, pa_ra, qf_ra, ql_ra;
	idx_t nl_rd, pl_rd, hq_rd, pa_rd, qf_rd, ql_rd;

	logic cmd_ok, rd_load;

	assign cmd_ok = in_range(in_data.first_operand) && in_range(in_data.second_operand);
	assign rd_load = (state_q == ST_RD) && (!out_valid_q || out_ready);
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	mqmm_ram #(.WIDTH(IDX_W), .DEPTH(TBL_DEPTH)) u_next (
		.clk, .we(nl_we), .waddr(nl_wa), .wdata(nl_wd), .re(nl_re), .raddr(nl_ra),
		.rdata(nl_rd));
	mqmm_ram #(.WIDTH(IDX_W), .DEPTH(TBL_DEPTH)) u_prev (
		.clk, .we(pl_we), .waddr(pl_wa), .wdata(pl_wd), .re(pl_re), .raddr(pl_ra),
		.rdata(pl_rd));
	mqmm_ram #(.WIDTH(IDX_W), .DEPTH(TBL_DEPTH)) u_home (
		.clk, .we(hq_we), .waddr(hq_wa), .wdata(hq_wd), .re(hq_re), .raddr(hq_ra),
		.rdata(hq_rd));
	mqmm_ram #(.WIDTH(IDX_W), .DEPTH(TBL_DEPTH)) u_parent (
		.clk, .we(pa_we), .waddr(pa_wa), .wdata(pa_wd), .re(pa_re), .raddr(pa_ra),
		.rdata(pa_rd));
	mqmm_ram #(.WIDTH(IDX_W), .DEPTH(TBL_DEPTH)) u_first (
		.clk, .we(qf_we), .waddr(qf_wa), .wdata(qf_wd), .re(qf_re), .raddr(qf_ra),
		.rdata(qf_rd));
	mqmm_ram #(.WIDTH(IDX_W), .DEPTH(TBL_DEPTH)) u_last (
		.clk, .we(ql_we), .waddr(ql_wa), .wdata(ql_wd), .re(ql_re), .raddr(ql_ra),
		.rdata(ql_rd));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLR: begin
				if (clr_q == idx_t'(TBL_DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					case (in_data.operation)
						OP_MOVE:  if (cmd_ok) state_d = ST_MV_LD;
						OP_MERGE: if (cmd_ok) state_d = ST_FIND_A;
						OP_READ:  state_d = ST_RD;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_MV_LD:  state_d = ST_FIND_A;
			ST_FIND_A: if (pa_rd == cur_q) state_d = ST_FIND_B;
			ST_FIND_B: begin
				if (pa_rd == cur_q) begin
					if (op_q == OP_MOVE) state_d = ST_MV_A;
					else if (ra_q == cur_q) state_d = ST_IDLE;
					else state_d = ST_MG_A;
				end
			end
			ST_MV_A: state_d = ST_MV_B;
			ST_MV_B: state_d = ST_MV_C;
			ST_MV_C: state_d = ST_MV_D;
			ST_MV_D: state_d = ST_IDLE;
			ST_MG_A: state_d = ST_MG_B;
			ST_MG_B: state_d = ST_MG_C;
			ST_MG_C: state_d = ST_MG_D;
			ST_MG_D: state_d = ST_IDLE;
			ST_RD:   if (rd_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// table controls
	always_comb begin
		nl_we = 1'b0; pl_we = 1'b0; hq_we = 1'b0; pa_we = 1'b0; qf_we = 1'b0; ql_we = 1'b0;
		nl_re = 1'b0; pl_re = 1'b0; hq_re = 1'b0; pa_re = 1'b0; qf_re = 1'b0; ql_re = 1'b0;
		nl_wa = '0; pl_wa = '0; hq_wa = '0; pa_wa = '0; qf_wa = '0; ql_wa = '0;
		nl_wd = '0; pl_wd = '0; hq_wd = '0; pa_wd = '0; qf_wd = '0; ql_wd = '0;
		nl_ra = '0; pl_ra = '0; hq_ra = '0; pa_ra = '0; qf_ra = '0; ql_ra = '0;
		case (state_q)
			ST_CLR: begin
				nl_we = 1'b1; pl_we = 1'b1; hq_we = 1'b1;
				pa_we = 1'b1; qf_we = 1'b1; ql_we = 1'b1;
				nl_wa = clr_q; pl_wa = clr_q; hq_wa = clr_q;
				pa_wa = clr_q; qf_wa = clr_q; ql_wa = clr_q;
				hq_wd = clr_q; pa_wd = clr_q; qf_wd = clr_q; ql_wd = clr_q;
			end
			ST_IDLE: begin
				if (in_valid) begin
					case (in_data.operation)
						OP_MOVE: begin
							hq_re = cmd_ok; nl_re = cmd_ok; pl_re = cmd_ok;
							hq_ra = in_data.first_operand;
							nl_ra = in_data.first_operand;
							pl_ra = in_data.first_operand;
						end
						OP_MERGE: begin
							pa_re = cmd_ok;
							pa_ra = in_data.first_operand;
						end
						OP_READ: begin
							qf_re = 1'b1; nl_re = 1'b1;
							qf_ra = in_data.first_operand;
							nl_ra = in_data.second_operand;
						end
						default: ;
					endcase
				end
			end
			ST_MV_LD: begin
				pa_re = 1'b1;
				pa_ra = hq_rd;
			end
			ST_FIND_A, ST_FIND_B: begin
				if (pa_rd == cur_q) begin
					pa_we = 1'b1;
					pa_wa = start_q;
					pa_wd = cur_q;
					if (state_q == ST_FIND_A) begin
						pa_re = 1'b1;
						pa_ra = b_q;
					end
				end else begin
					pa_re = 1'b1;
					pa_ra = pa_rd;
				end
			end
			ST_MV_A: begin
				qf_re = 1'b1; ql_re = 1'b1;
				qf_ra = ra_q; ql_ra = ra_q;
				pl_we = (nx_q != '0); pl_wa = nx_q; pl_wd = pv_q;
				nl_we = (pv_q != '0); nl_wa = pv_q; nl_wd = nx_q;
			end
			ST_MV_B: begin
				qf_we = (qf_rd == a_q); qf_wa = ra_q; qf_wd = nx_q;
				ql_we = (ql_rd == a_q); ql_wa = ra_q; ql_wd = pv_q;
			end
			ST_MV_C: begin
				qf_re = 1'b1; ql_re = 1'b1;
				qf_ra = rb_q; ql_ra = rb_q;
				nl_we = 1'b1; nl_wa = a_q; nl_wd = '0;
			end
			ST_MV_D: begin
				pl_we = 1'b1; pl_wa = a_q; pl_wd = ql_rd;
				if (qf_rd == '0) begin
					qf_we = 1'b1; qf_wa = rb_q; qf_wd = a_q;
				end else begin
					nl_we = 1'b1; nl_wa = ql_rd; nl_wd = a_q;
				end
				ql_we = 1'b1; ql_wa = rb_q; ql_wd = a_q;
				hq_we = 1'b1; hq_wa = a_q; hq_wd = rb_q;
			end
			ST_MG_A: begin
				pa_we = 1'b1; pa_wa = ra_q; pa_wd = rb_q;
				qf_re = 1'b1; ql_re = 1'b1;
				qf_ra = ra_q; ql_ra = ra_q;
			end
			ST_MG_B: begin
				qf_re = 1'b1; ql_re = 1'b1;
				qf_ra = rb_q; ql_ra = rb_q;
			end
			ST_MG_C: begin
				if (qfa_q != '0) begin
					if (qf_rd == '0) begin
						qf_we = 1'b1; qf_wa = rb_q; qf_wd = qfa_q;
					end else begin
						nl_we = 1'b1; nl_wa = ql_rd; nl_wd = qfa_q;
						pl_we = 1'b1; pl_wa = qfa_q; pl_wd = ql_rd;
					end
					ql_we = 1'b1; ql_wa = rb_q; ql_wd = qla_q;
				end
			end
			ST_MG_D: begin
				qf_we = 1'b1; qf_wa = ra_q; qf_wd = '0;
				ql_we = 1'b1; ql_wa = ra_q; ql_wd = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR) clr_q <= clr_q + idx_t'(1);
			if (rd_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q <= in_data.operation;
				a_q <= in_data.first_operand;
				b_q <= in_data.second_operand;
				cur_q <= in_data.first_operand;
				start_q <= in_data.first_operand;
			end
			ST_MV_LD: begin
				cur_q <= hq_rd;
				start_q <= hq_rd;
				nx_q <= nl_rd;
				pv_q <= pl_rd;
			end
			ST_FIND_A: begin
				if (pa_rd == cur_q) begin
					ra_q <= cur_q;
					cur_q <= b_q;
					start_q <= b_q;
				end else begin
					cur_q <= pa_rd;
				end
			end
			ST_FIND_B: begin
				if (pa_rd == cur_q) rb_q <= cur_q;
				else cur_q <= pa_rd;
			end
			ST_MG_B: begin
				qfa_q <= qf_rd;
				qla_q <= ql_rd;
			end
			ST_RD: begin
				if (rd_load) begin
					out_q.queue_head <= in_range(a_q) ? qf_rd : '0;
					out_q.item_successor <= in_range(b_q) ? nl_rd : '0;
				end
			end
			default: ;
		endcase
	end

endmodule
